// ===== hw/rtl/pfc_pkg.sv =====
// Pixel format converter package: format codes, shared types and the
// float/unorm helper functions used by decode, encode and quantise lanes.
`timescale 1ns / 1ps
package pfc_pkg;

	localparam logic [4:0] FMT_R8       = 5'd0;
	localparam logic [4:0] FMT_RGBA8    = 5'd2;
	localparam logic [4:0] FMT_R16      = 5'd3;
	localparam logic [4:0] FMT_RGBA16   = 5'd5;
	localparam logic [4:0] FMT_R16F     = 5'd6;
	localparam logic [4:0] FMT_R32F     = 5'd9;
	localparam logic [4:0] FMT_RGBA32F  = 5'd11;
	localparam logic [4:0] FMT_RGBA4    = 5'd12;
	localparam logic [4:0] FMT_RGB5A1   = 5'd13;
	localparam logic [4:0] FMT_RGB565   = 5'd14;
	localparam logic [4:0] FMT_RGB10A2  = 5'd15;
	localparam logic [4:0] FMT_RG11B10F = 5'd16;

	localparam logic [1:0] GRP_U8  = 2'd0;
	localparam logic [1:0] GRP_U16 = 2'd1;
	localparam logic [1:0] GRP_F16 = 2'd2;
	localparam logic [1:0] GRP_F32 = 2'd3;

	localparam logic [31:0] F32_ONE = 32'h3F80_0000;

	typedef logic [3:0][31:0] quad_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

	// channel count of the plain formats (codes below RGBA4)
	function automatic logic [2:0] fmt_chans(input logic [4:0] fmt);
		logic [2:0] n;
		unique case (fmt)
			5'd0, 5'd3, 5'd6, 5'd9:  n = 3'd1;
			5'd1, 5'd4, 5'd7, 5'd10: n = 3'd2;
			default:                 n = 3'd4;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] fmt_group(input logic [4:0] fmt);
		logic [1:0] g;
		if (fmt < FMT_R16)
			g = GRP_U8;
		else if (fmt < FMT_R16F)
			g = GRP_U16;
		else if (fmt < FMT_R32F)
			g = GRP_F16;
		else
			g = GRP_F32;
		return g;
	endfunction

	// unorm channel maximum for a target lane
	function automatic logic [15:0] unorm_scale(input logic [4:0] fmt, input logic [1:0] lane);
		logic [15:0] s;
		unique case (fmt)
			5'd3, 5'd4, 5'd5: s = 16'hFFFF;
			FMT_RGBA4:        s = 16'h000F;
			FMT_RGB5A1:       s = (lane == 2'd3) ? 16'h0001 : 16'h001F;
			FMT_RGB565:       s = (lane == 2'd1) ? 16'h003F : 16'h001F;
			FMT_RGB10A2:      s = (lane == 2'd3) ? 16'h0003 : 16'h03FF;
			default:          s = 16'h00FF;
		endcase
		return s;
	endfunction

	// k / (2^nb - 1) rounded to float32; the quotient is k's bits repeated
	function automatic logic [31:0] unorm_to_f32(input logic [15:0] k, input logic [4:0] nb);
		logic [47:0] r;
		logic [49:0] t50;
		logic [15:0] mx;
		logic [3:0]  lz;
		logic        found;
		logic [47:0] nrm;
		logic [23:0] mr;
		logic [31:0] res;
		t50 = '0;
		unique case (nb)
			5'd1:  begin r = {48{k[0]}};      mx = 16'h0001; end
			5'd2:  begin r = {24{k[1:0]}};    mx = 16'h0003; end
			5'd4:  begin r = {12{k[3:0]}};    mx = 16'h000F; end
			5'd5:  begin t50 = {10{k[4:0]}}; r = t50[49:2]; mx = 16'h001F; end
			5'd6:  begin r = {8{k[5:0]}};     mx = 16'h003F; end
			5'd8:  begin r = {6{k[7:0]}};     mx = 16'h00FF; end
			5'd10: begin t50 = {5{k[9:0]}};  r = t50[49:2]; mx = 16'h03FF; end
			default: begin r = {3{k}};        mx = 16'hFFFF; end
		endcase
		lz = '0;
		found = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (!found && r[47-i]) begin
				lz = 4'(i);
				found = 1'b1;
			end
		end
		nrm = r << (6'(lz) + 6'd1);
		mr = {1'b0, nrm[47:25]} + 24'(nrm[24]);
		if (k == 16'd0)
			res = '0;
		else if (k == mx)
			res = F32_ONE;
		else
			res = {1'b0, 8'd126 - 8'(lz), 23'b0} + 32'(mr);
		return res;
	endfunction

	// half to float32; the small unsigned floats are fed in mantissa-aligned
	function automatic logic [31:0] half_to_f32(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  mm;
		logic [3:0]  p;
		logic [23:0] sh;
		logic [31:0] res;
		e = h[14:10];
		mm = h[9:0];
		p = '0;
		for (int i = 0; i < 10; i++)
			if (mm[i]) p = 4'(i);
		sh = 24'(mm) << (5'd23 - 5'(p));
		if (e == 5'd31)
			res = {h[15], 8'hFF, (mm != 10'd0) ? (23'h40_0000 | {mm, 13'b0}) : 23'b0};
		else if (e == 5'd0)
			res = (mm == 10'd0) ? {h[15], 31'b0} : {h[15], 8'd103 + 8'(p), sh[22:0]};
		else
			res = {h[15], 8'(e) + 8'd112, mm, 13'b0};
		return res;
	endfunction

	// non-NaN float32 magnitude to a small float with m mantissa bits, nearest even
	function automatic logic [15:0] mag_to_small(input logic [30:0] a, input logic [3:0] m);
		logic [7:0]  ex;
		logic [8:0]  s;
		logic [31:0] base;
		logic [31:0] src;
		logic [4:0]  sh;
		logic [31:0] keep;
		logic [31:0] rem;
		logic [31:0] halfv;
		logic [31:0] res;
		ex = a[30:23];
		s = 9'd136 - 9'(m) - 9'(ex);
		if (ex >= 8'd113) begin
			base = 32'(ex - 8'd112) << m;
			src = 32'(a[22:0]);
			sh = 5'd23 - 5'(m);
		end else begin
			base = '0;
			src = {8'b0, ex != 8'd0, a[22:0]};
			sh = s[4:0];
		end
		keep = src >> sh;
		rem = src & ((32'd1 << sh) - 32'd1);
		halfv = 32'd1 << (sh - 5'd1);
		res = base | keep;
		if (rem > halfv || (rem == halfv && keep[0]))
			res = res + 32'd1;
		if (ex >= 8'd143)
			res = 32'd31 << m;
		else if (ex < 8'd113 && s >= 9'd25)
			res = '0;
		return res[15:0];
	endfunction

	function automatic logic [15:0] f32_to_half(input logic [31:0] b);
		logic [15:0] mg;
		logic [15:0] res;
		mg = mag_to_small(b[30:0], 4'd10);
		if (b[30:0] > 31'h7F80_0000)
			res = {b[31], 6'b111111, b[21:13]};
		else
			res = {b[31], mg[14:0]};
		return res;
	endfunction

	function automatic logic [15:0] f32_to_usmall(input logic [31:0] b, input logic [3:0] m);
		logic [15:0] res;
		if (b[30:0] > 31'h7F80_0000)
			res = (16'd31 << m) | (16'd1 << (m - 4'd1));
		else if (b[31])
			res = '0;
		else
			res = mag_to_small(b[30:0], m);
		return res;
	endfunction

endpackage

// ===== hw/rtl/pixel_format_converter.sv =====
// Pixel format converter top level: config registers, pipeline control,
// final packing. Uses pfc_pkg, pfc_decode, pfc_float_enc, pfc_quant.
//
//   port group   direction   handshake             payload
//   in           to block    in_valid / in_stall   in_chan_r/g/b/a
//   out          from block  out_valid / out_stall out_chan_r/g/b/a
//   cfg          to block    cfg_we                cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each item passes every stage register in order.
// The depth is set by the quantise lanes: multiply, round, add a half, round.
// Each stage holds while the one after it is full and stalled; in_stall
// rises only when all six stages are full and out_stall is high.
// Reset sets both formats to RGBA8 and empties the pipeline.
`timescale 1ns / 1ps
module pixel_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] in_chan_r,
	input  logic [31:0] in_chan_g,
	input  logic [31:0] in_chan_b,
	input  logic [31:0] in_chan_a,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_chan_r,
	output logic [31:0] out_chan_g,
	output logic [31:0] out_chan_b,
	output logic [31:0] out_chan_a
);
	import pfc_pkg::*;

	localparam logic CFG_SOURCE = 1'b0;
	localparam logic CFG_TARGET = 1'b1;

	logic [4:0] src_fmt_q;
	logic [4:0] tgt_fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_RGBA8;
			tgt_fmt_q <= FMT_RGBA8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE: src_fmt_q <= cfg_data;
				CFG_TARGET: tgt_fmt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic a1, a2, a6;
	adv_t adv;

	assign a6 = !v_s6 || !out_stall;
	assign adv.s5 = !v_s5 || a6;
	assign adv.s4 = !v_s4 || adv.s5;
	assign adv.s3 = !v_s3 || adv.s4;
	assign a2 = !v_s2 || adv.s3;
	assign a1 = !v_s1 || a2;
	assign in_stall = !a1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (a1) v_s1 <= in_valid;
			if (a2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
			if (a6) v_s6 <= v_s5;
		end
	end

	// input register
	quad_t raw_s1;

	always_ff @(posedge clk) begin
		if (a1)
			raw_s1 <= {in_chan_a, in_chan_b, in_chan_g, in_chan_r};
	end

	// decode
	quad_t chan;
	quad_t dval;
	logic  direct;
	quad_t chan_s2;
	quad_t dval_s2;
	logic  direct_s2;

	pfc_decode u_decode (
		.src_fmt    (src_fmt_q),
		.tgt_fmt    (tgt_fmt_q),
		.raw        (raw_s1),
		.chan       (chan),
		.direct     (direct),
		.direct_val (dval)
	);

	always_ff @(posedge clk) begin
		if (a2) begin
			chan_s2 <= chan;
			dval_s2 <= dval;
			direct_s2 <= direct;
		end
	end

	// float encode and quantise lanes
	quad_t enc;
	logic  useq;
	quad_t pre_s3, pre_s4, pre_s5;
	logic  useq_s3, useq_s4, useq_s5;
	logic [15:0] q [4];

	pfc_float_enc u_float_enc (
		.tgt_fmt (tgt_fmt_q),
		.chan    (chan_s2),
		.enc     (enc)
	);

	assign useq = !direct_s2 && (tgt_fmt_q <= FMT_RGBA16 ||
		(tgt_fmt_q >= FMT_RGBA4 && tgt_fmt_q <= FMT_RGB10A2));

	for (genvar i = 0; i < 4; i++) begin : g_lane
		pfc_quant u_quant (
			.clk (clk),
			.adv (adv),
			.x   (chan_s2[i]),
			.scl (unorm_scale(tgt_fmt_q, 2'(i))),
			.q   (q[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			pre_s3 <= direct_s2 ? dval_s2 : enc;
			useq_s3 <= useq;
		end
		if (adv.s4) begin
			pre_s4 <= pre_s3;
			useq_s4 <= useq_s3;
		end
		if (adv.s5) begin
			pre_s5 <= pre_s4;
			useq_s5 <= useq_s4;
		end
	end

	// unorm packing
	quad_t  packed_q;
	quad_t  res;
	logic [2:0] tn;

	assign tn = fmt_chans(tgt_fmt_q);

	always_comb begin
		packed_q = '0;
		unique case (tgt_fmt_q)
			FMT_RGBA4:
				packed_q[0] = {16'b0, q[0][3:0], q[1][3:0], q[2][3:0], q[3][3:0]};
			FMT_RGB5A1:
				packed_q[0] = {16'b0, q[0][4:0], q[1][4:0], q[2][4:0], q[3][0]};
			FMT_RGB565:
				packed_q[0] = {16'b0, q[0][4:0], q[1][5:0], q[2][4:0]};
			FMT_RGB10A2:
				packed_q[0] = {q[3][1:0], q[2][9:0], q[1][9:0], q[0][9:0]};
			default: begin
				for (int i = 0; i < 4; i++)
					if (3'(i) < tn) packed_q[i] = {16'b0, q[i]};
			end
		endcase
		res = useq_s5 ? packed_q : pre_s5;
	end

	always_ff @(posedge clk) begin
		if (a6) begin
			out_chan_r <= res[0];
			out_chan_g <= res[1];
			out_chan_b <= res[2];
			out_chan_a <= res[3];
		end
	end

endmodule

// ===== hw/rtl/pfc_decode.sv =====
// Source decode: raw channel words to float32 RGBA, plus the direct results
// (pass-through, 8/16-bit shifts, invalid codes). Uses pfc_pkg.
`timescale 1ns / 1ps
module pfc_decode (
	input  logic [4:0]     src_fmt,
	input  logic [4:0]     tgt_fmt,
	input  pfc_pkg::quad_t raw,
	output pfc_pkg::quad_t chan,
	output logic           direct,
	output pfc_pkg::quad_t direct_val
);
	import pfc_pkg::*;

	logic [31:0] p;
	logic [2:0]  n;
	logic [1:0]  grp;

	assign p = raw[0];
	assign n = fmt_chans(src_fmt);
	assign grp = fmt_group(src_fmt);

	always_comb begin
		chan = '0;
		chan[3] = F32_ONE;
		if (src_fmt < FMT_RGBA4) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < n) begin
					unique case (grp)
						GRP_U8:  chan[i] = unorm_to_f32({8'b0, raw[i][7:0]}, 5'd8);
						GRP_U16: chan[i] = unorm_to_f32(raw[i][15:0], 5'd16);
						GRP_F16: chan[i] = half_to_f32(raw[i][15:0]);
						default: chan[i] = raw[i];
					endcase
				end
			end
		end else begin
			unique case (src_fmt)
				FMT_RGBA4: begin
					chan[0] = unorm_to_f32({12'b0, p[15:12]}, 5'd4);
					chan[1] = unorm_to_f32({12'b0, p[11:8]}, 5'd4);
					chan[2] = unorm_to_f32({12'b0, p[7:4]}, 5'd4);
					chan[3] = unorm_to_f32({12'b0, p[3:0]}, 5'd4);
				end
				FMT_RGB5A1: begin
					chan[0] = unorm_to_f32({11'b0, p[15:11]}, 5'd5);
					chan[1] = unorm_to_f32({11'b0, p[10:6]}, 5'd5);
					chan[2] = unorm_to_f32({11'b0, p[5:1]}, 5'd5);
					chan[3] = unorm_to_f32({15'b0, p[0]}, 5'd1);
				end
				FMT_RGB565: begin
					chan[0] = unorm_to_f32({11'b0, p[15:11]}, 5'd5);
					chan[1] = unorm_to_f32({10'b0, p[10:5]}, 5'd6);
					chan[2] = unorm_to_f32({11'b0, p[4:0]}, 5'd5);
				end
				FMT_RGB10A2: begin
					chan[0] = unorm_to_f32({6'b0, p[9:0]}, 5'd10);
					chan[1] = unorm_to_f32({6'b0, p[19:10]}, 5'd10);
					chan[2] = unorm_to_f32({6'b0, p[29:20]}, 5'd10);
					chan[3] = unorm_to_f32({14'b0, p[31:30]}, 5'd2);
				end
				FMT_RG11B10F: begin
					chan[0] = half_to_f32({1'b0, p[10:6], p[5:0], 4'b0});
					chan[1] = half_to_f32({1'b0, p[21:17], p[16:11], 4'b0});
					chan[2] = half_to_f32({1'b0, p[31:27], p[26:22], 5'b0});
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		direct = 1'b1;
		direct_val = '0;
		if (src_fmt > FMT_RG11B10F || tgt_fmt > FMT_RG11B10F) begin
			direct_val = '0;
		end else if (src_fmt == tgt_fmt) begin
			if (src_fmt < FMT_RGBA4) begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < n) begin
						unique case (grp)
							GRP_U8:  direct_val[i] = {24'b0, raw[i][7:0]};
							GRP_F32: direct_val[i] = raw[i];
							default: direct_val[i] = {16'b0, raw[i][15:0]};
						endcase
					end
				end
			end else begin
				direct_val[0] = (src_fmt <= FMT_RGB565) ? {16'b0, p[15:0]} : p;
			end
		end else if (src_fmt == FMT_RGBA8 && tgt_fmt == FMT_RGBA16) begin
			for (int i = 0; i < 4; i++)
				direct_val[i] = {16'b0, raw[i][7:0], 8'b0};
		end else if (src_fmt == FMT_RGBA16 && tgt_fmt == FMT_RGBA8) begin
			for (int i = 0; i < 4; i++)
				direct_val[i] = {24'b0, raw[i][15:8]};
		end else begin
			direct = 1'b0;
		end
	end

endmodule

// ===== hw/rtl/pfc_float_enc.sv =====
// Float target encode: float32 RGBA to half, float32 and RG11B10F words.
// Uses pfc_pkg.
`timescale 1ns / 1ps
module pfc_float_enc (
	input  logic [4:0]     tgt_fmt,
	input  pfc_pkg::quad_t chan,
	output pfc_pkg::quad_t enc
);
	import pfc_pkg::*;

	logic [2:0]  n;
	logic [15:0] us_r;
	logic [15:0] us_g;
	logic [15:0] us_b;
	logic [15:0] hf [4];

	assign n = fmt_chans(tgt_fmt);
	assign us_r = f32_to_usmall(chan[0], 4'd6);
	assign us_g = f32_to_usmall(chan[1], 4'd6);
	assign us_b = f32_to_usmall(chan[2], 4'd5);

	always_comb begin
		for (int i = 0; i < 4; i++)
			hf[i] = f32_to_half(chan[i]);
	end

	always_comb begin
		enc = '0;
		if (tgt_fmt >= FMT_R16F && tgt_fmt <= FMT_RGBA32F) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < n)
					enc[i] = (tgt_fmt < FMT_R32F) ? {16'b0, hf[i]} : chan[i];
			end
		end else if (tgt_fmt == FMT_RG11B10F) begin
			enc[0] = {us_b[9:0], us_g[10:0], us_r[10:0]};
		end
	end

endmodule

// ===== hw/rtl/pfc_quant.sv =====
// One unorm quantise lane: clamp, multiply by the channel maximum with
// float32 rounding, add one half with float32 rounding, truncate. Uses pfc_pkg.
`timescale 1ns / 1ps
module pfc_quant (
	input  logic          clk,
	input  pfc_pkg::adv_t adv,
	input  logic [31:0]   x,
	input  logic [15:0]   scl,
	output logic [15:0]   q
);
	import pfc_pkg::*;

	typedef enum logic [1:0] {QM_ZERO, QM_ONE, QM_MUL} qmode_t;

	qmode_t      m3;
	logic [39:0] p_s3;
	logic [5:0]  ex_s3;
	qmode_t      mode_s3;
	logic [15:0] scl_s3;

	always_comb begin
		priority if (x[31] || x[30:0] == 31'd0 || x[30:0] > 31'h7F80_0000)
			m3 = QM_ZERO;
		else if (x[30:0] >= F32_ONE[30:0])
			m3 = QM_ONE;
		else if (x[30:23] < 8'd87)
			m3 = QM_ZERO;
		else
			m3 = QM_MUL;
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			p_s3 <= 40'({1'b1, x[22:0]}) * 40'(scl);
			ex_s3 <= 6'(x[30:23] - 8'd87);
			mode_s3 <= m3;
			scl_s3 <= scl;
		end
	end

	// round the product to 24 significant bits
	logic [5:0]  h;
	logic [4:0]  sh;
	logic [39:0] keep;
	logic [39:0] rem;
	logic [39:0] halfv;
	logic        inc4;
	logic [24:0] r25;
	logic [6:0]  esum;
	logic [23:0] r_s4;
	logic [4:0]  lsh_s4;
	qmode_t      mode_s4;
	logic [15:0] scl_s4;

	always_comb begin
		h = '0;
		for (int i = 0; i < 40; i++)
			if (p_s3[i]) h = 6'(i);
		sh = 5'(h - 6'd23);
		keep = p_s3 >> sh;
		rem = p_s3 & ((40'd1 << sh) - 40'd1);
		halfv = 40'd1 << (sh - 5'd1);
		inc4 = (sh != 5'd0) && (rem > halfv || (rem == halfv && keep[0]));
		r25 = {1'b0, keep[23:0]} + 25'(inc4);
		esum = 7'(h) + 7'(r25[24]) + 7'(ex_s3);
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			r_s4 <= r25[24] ? 24'h80_0000 : r25[23:0];
			lsh_s4 <= 5'(esum - 7'd60);
			mode_s4 <= (mode_s3 == QM_MUL && esum < 7'd60) ? QM_ZERO : mode_s3;
			scl_s4 <= scl_s3;
		end
	end

	// fixed point with 26 fraction bits, plus one half
	logic [42:0] u_s5;
	qmode_t      mode_s5;
	logic [15:0] scl_s5;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			u_s5 <= (43'(r_s4) << lsh_s4) + (43'd1 << 25);
			mode_s5 <= mode_s4;
			scl_s5 <= scl_s4;
		end
	end

	// round the sum to 24 significant bits and keep the integer part
	logic [5:0]  g;
	logic [4:0]  j;
	logic [42:0] lowm;
	logic [42:0] urem;
	logic [42:0] uhalf;
	logic        inc6;
	logic [43:0] v;

	always_comb begin
		g = '0;
		for (int i = 0; i < 43; i++)
			if (u_s5[i]) g = 6'(i);
		j = 5'(g - 6'd23);
		lowm = (43'd1 << j) - 43'd1;
		urem = u_s5 & lowm;
		uhalf = 43'd1 << (j - 5'd1);
		inc6 = urem > uhalf || (urem == uhalf && u_s5[j]);
		v = {1'b0, u_s5 & ~lowm} + (inc6 ? (44'd1 << j) : 44'd0);
		unique case (mode_s5)
			QM_ONE:  q = scl_s5;
			QM_MUL:  q = v[41:26];
			default: q = '0;
		endcase
	end

endmodule

// ===== dv/tb_pixel_format_converter.sv =====
// Testbench for pixel_format_converter: a directed table then random phases
// of formats and pixels, checked against a bit-exact predictor in this file.
// Depends on pfc_pkg (format codes and types) and the converter RTL only.
`timescale 1ns / 1ps
module tb_pixel_format_converter;
	import pfc_pkg::*;

	localparam logic [4:0] FMT_RG8     = 5'd1;
	localparam logic [4:0] FMT_RG16    = 5'd4;
	localparam logic [4:0] FMT_RG16F   = 5'd7;
	localparam logic [4:0] FMT_RGBA16F = 5'd8;
	localparam logic [4:0] FMT_RG32F   = 5'd10;
	localparam logic [4:0] FMT_COUNT   = 5'd17;
	localparam logic [4:0] FMT_BAD_MAX = 5'd31;
	localparam logic       REG_SRC     = 1'b0;
	localparam logic       REG_DST     = 1'b1;
	localparam int         PIPE_DEPTH  = 6;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         RAND_ITEMS  = 1200;

	typedef struct {
		logic [4:0] src;
		logic [4:0] dst;
		quad_t      pix;
		bit         fixed;
		quad_t      want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] in_chan_r = '0, in_chan_g = '0, in_chan_b = '0, in_chan_a = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_chan_r, out_chan_g, out_chan_b, out_chan_a;

	logic [4:0]  cur_src = FMT_RGBA8;
	logic [4:0]  cur_dst = FMT_RGBA8;
	quad_t       pixel_q[$];
	row_t        dir_tab[$];
	int          errors = 0;
	int          cycles = 0;
	bit          hold_req = 1'b0;
	bit          quiet = 1'b0;

	pixel_format_converter dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL pixel_format_converter");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic logic [31:0] to_f32(input real r);
		logic [63:0] d;
		logic [31:0] res;
		logic [28:0] rem;
		if (r == 0.0)
			return '0;
		d = $realtobits(r);
		res = (32'(d[62:52] - 11'd896) << 23) | 32'(d[51:29]);
		rem = d[28:0];
		if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && res[0]))
			res = res + 32'd1;
		return res;
	endfunction

	function automatic real f32_val(input logic [31:0] b);
		return $bitstoreal({1'b0, 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
	endfunction

	function automatic logic [31:0] quantise(input logic [31:0] b, input real scale);
		real x;
		logic [31:0] t;
		if (b[30:0] > 31'h7F80_0000 || b[31] || b[30:23] == 8'd0)
			return '0;
		x = (b[30:0] >= 31'h3F80_0000) ? 1.0 : f32_val(b);
		t = to_f32(x * scale);
		t = to_f32(f32_val(t) + 0.5);
		return 32'($rtoi(f32_val(t)));
	endfunction

	function automatic logic [31:0] unorm_dec(input logic [31:0] k, input real mx);
		if (k == 0)
			return '0;
		return to_f32(real'(k) / mx);
	endfunction

	function automatic logic [31:0] small_dec(input logic [31:0] v, input int m, input logic sgn);
		logic [31:0] e, mm;
		e = (v >> m) & 32'h1F;
		mm = v & ((32'd1 << m) - 1);
		if (e == 31)
			return {sgn, 31'h7F80_0000 | ((mm != 0) ? (31'h40_0000 | 31'(mm << (23 - m))) : 31'd0)};
		if (e == 0)
			return {sgn, 31'(to_f32(real'(mm) / real'(64'd1 << (14 + m))))};
		return {sgn, 31'(((e + 112) << 23) | (mm << (23 - m)))};
	endfunction

	function automatic logic [31:0] mag_small(input logic [31:0] a, input int m);
		int ex, e, te, sh;
		logic [31:0] man, keep, rem, hlf, res, sig;
		ex = int'(a[30:23]);
		man = {9'b0, a[22:0]};
		e = ex - 127;
		te = e + 15;
		if (ex == 255 || te >= 31)
			return 32'd31 << m;
		if (te >= 1) begin
			sh = 23 - m;
			keep = man >> sh;
			rem = man & ((32'd1 << sh) - 1);
			hlf = 32'd1 << (sh - 1);
			res = (32'(te) << m) | keep;
		end else begin
			sig = (ex != 0) ? (man | 32'h80_0000) : man;
			sh = 9 - m - e;
			if (sh >= 25)
				return '0;
			keep = sig >> sh;
			rem = sig & ((32'd1 << sh) - 1);
			hlf = 32'd1 << (sh - 1);
			res = keep;
		end
		if (rem > hlf || (rem == hlf && keep[0]))
			res = res + 1;
		return res;
	endfunction

	function automatic logic [31:0] half_enc(input logic [31:0] b);
		if (b[30:0] > 31'h7F80_0000)
			return {16'b0, b[31], 5'h1F, 1'b1, 9'(b[30:13] & 18'h1FF) } | 32'h0;
		return {16'b0, b[31], 15'(mag_small({1'b0, b[30:0]}, 10))};
	endfunction

	function automatic logic [31:0] usmall_enc(input logic [31:0] b, input int m);
		if (b[30:0] > 31'h7F80_0000)
			return (32'd31 << m) | (32'd1 << (m - 1));
		if (b[31])
			return '0;
		return mag_small({1'b0, b[30:0]}, m);
	endfunction

	function automatic int chans(input logic [4:0] f);
		return (f % 3 == 0) ? 1 : ((f % 3 == 1) ? 2 : 4);
	endfunction

	function automatic quad_t decode_px(input logic [4:0] f, input quad_t v);
		quad_t c;
		logic [31:0] p;
		p = v[0];
		c = '0;
		c[3] = F32_ONE;
		if (f < FMT_RGBA4) begin
			for (int i = 0; i < chans(f); i++)
				case (f / 3)
					0: c[i] = unorm_dec(v[i] & 32'hFF, 255.0);
					1: c[i] = unorm_dec(v[i] & 32'hFFFF, 65535.0);
					2: c[i] = small_dec(v[i] & 32'h7FFF, 10, v[i][15]);
					default: c[i] = v[i];
				endcase
		end else
			case (f)
				FMT_RGBA4: for (int i = 0; i < 4; i++)
					c[i] = unorm_dec((p >> (12 - 4 * i)) & 32'hF, 15.0);
				FMT_RGB5A1: begin
					c[0] = unorm_dec((p >> 11) & 32'h1F, 31.0);
					c[1] = unorm_dec((p >> 6) & 32'h1F, 31.0);
					c[2] = unorm_dec((p >> 1) & 32'h1F, 31.0);
					c[3] = unorm_dec(p & 32'h1, 1.0);
				end
				FMT_RGB565: begin
					c[0] = unorm_dec((p >> 11) & 32'h1F, 31.0);
					c[1] = unorm_dec((p >> 5) & 32'h3F, 63.0);
					c[2] = unorm_dec(p & 32'h1F, 31.0);
				end
				FMT_RGB10A2: begin
					for (int i = 0; i < 3; i++)
						c[i] = unorm_dec((p >> (10 * i)) & 32'h3FF, 1023.0);
					c[3] = unorm_dec((p >> 30) & 32'h3, 3.0);
				end
				default: begin
					c[0] = small_dec(p & 32'h7FF, 6, 1'b0);
					c[1] = small_dec((p >> 11) & 32'h7FF, 6, 1'b0);
					c[2] = small_dec((p >> 22) & 32'h3FF, 5, 1'b0);
				end
			endcase
		return c;
	endfunction

	function automatic quad_t encode_px(input logic [4:0] f, input quad_t c);
		quad_t o;
		o = '0;
		if (f < FMT_RGBA4) begin
			for (int i = 0; i < chans(f); i++)
				case (f / 3)
					0: o[i] = quantise(c[i], 255.0);
					1: o[i] = quantise(c[i], 65535.0);
					2: o[i] = half_enc(c[i]);
					default: o[i] = c[i];
				endcase
		end else
			case (f)
				FMT_RGBA4: o[0] = (quantise(c[0], 15.0) << 12) | (quantise(c[1], 15.0) << 8)
					| (quantise(c[2], 15.0) << 4) | quantise(c[3], 15.0);
				FMT_RGB5A1: o[0] = (quantise(c[0], 31.0) << 11) | (quantise(c[1], 31.0) << 6)
					| (quantise(c[2], 31.0) << 1) | quantise(c[3], 1.0);
				FMT_RGB565: o[0] = (quantise(c[0], 31.0) << 11) | (quantise(c[1], 63.0) << 5)
					| quantise(c[2], 31.0);
				FMT_RGB10A2: o[0] = quantise(c[0], 1023.0) | (quantise(c[1], 1023.0) << 10)
					| (quantise(c[2], 1023.0) << 20) | (quantise(c[3], 3.0) << 30);
				default: o[0] = usmall_enc(c[0], 6) | (usmall_enc(c[1], 6) << 11)
					| (usmall_enc(c[2], 5) << 22);
			endcase
		return o;
	endfunction

	function automatic quad_t convert_px(input logic [4:0] s, input logic [4:0] t, input quad_t v);
		quad_t o;
		logic [31:0] mask;
		o = '0;
		if (s >= FMT_COUNT || t >= FMT_COUNT)
			return o;
		if (s == t) begin
			if (s < FMT_RGBA4) begin
				mask = (s / 3 == 0) ? 32'hFF : ((s / 3 == 3) ? 32'hFFFF_FFFF : 32'hFFFF);
				for (int i = 0; i < chans(s); i++)
					o[i] = v[i] & mask;
			end else
				o[0] = (s <= FMT_RGB565) ? (v[0] & 32'hFFFF) : v[0];
			return o;
		end
		if (s == FMT_RGBA8 && t == FMT_RGBA16) begin
			for (int i = 0; i < 4; i++)
				o[i] = (v[i] & 32'hFF) << 8;
			return o;
		end
		if (s == FMT_RGBA16 && t == FMT_RGBA8) begin
			for (int i = 0; i < 4; i++)
				o[i] = (v[i] & 32'hFFFF) >> 8;
			return o;
		end
		return encode_px(t, decode_px(s, v));
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		quad_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_chan_a, out_chan_b, out_chan_g, out_chan_r};
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, got);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (want[i] !== got[i]) begin
						$display("%0t: chan %0d expected %h actual %h", $time, i, want[i], got[i]);
						errors++;
					end
			end
		end
	end

	// ---------------- output stall ----------------
	initial begin
		int hold_cnt, run;
		hold_cnt = 0;
		run = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (run > 0)
				run--;
			else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic drain();
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic set_formats(input logic [4:0] s, input logic [4:0] t);
		if (s == cur_src && t == cur_dst)
			return;
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_SRC;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_DST;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_src = s;
		cur_dst = t;
	endtask

	task automatic send_pixel(input quad_t v, input bit fixed, input quad_t want);
		int gap;
		gap = quiet ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
			: (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{in_chan_a, in_chan_b, in_chan_g, in_chan_r} <= v;
		do
			@(posedge clk);
		while (in_stall);
		pixel_q.push_back(fixed ? want : convert_px(cur_src, cur_dst, v));
	endtask

	function automatic logic [31:0] rand_word();
		logic [31:0] specials[11] = '{32'h0, 32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7C00, 32'hFC00, 32'h7E01, 32'h1, 32'h8000_0000};
		case ($urandom_range(0, 9))
			3: return {1'b0, 8'($urandom_range(100, 127)), 23'($urandom)};
			4: return {1'($urandom), 8'($urandom_range(90, 150)), 23'($urandom)};
			5: return {16'($urandom), 1'($urandom), 5'($urandom_range(0, 15)), 10'($urandom)};
			6: return specials[$urandom_range(0, 10)];
			7: return {24'($urandom), 8'($urandom)} & {{24{1'($urandom)}}, 8'hFF};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] rand_fmt();
		if ($urandom_range(0, 19) == 0)
			return 5'($urandom_range(FMT_COUNT, FMT_BAD_MAX));
		return 5'($urandom_range(0, FMT_COUNT - 1));
	endfunction

	task automatic add_row(input logic [4:0] s, input logic [4:0] t, input quad_t v,
			input bit fixed, input quad_t want);
		row_t r;
		r.src = s;
		r.dst = t;
		r.pix = v;
		r.fixed = fixed;
		r.want = want;
		dir_tab.push_back(r);
	endtask

	initial begin
		int sent, plen;
		logic [4:0] s, t;
		quad_t v;
		// rows: {a, b, g, r}
		add_row(FMT_RGBA8, FMT_RGBA8, {32'hFFFF_FF78, 32'h1_0056, 32'hABCD_EF34, 32'hFFFF_FF12},
			1, {32'h78, 32'h56, 32'h34, 32'h12});
		add_row(FMT_RGBA8, FMT_RGBA16, {32'h0, 32'h1FF, 32'h180, 32'hFFFF_FFFF},
			1, {32'h0, 32'hFF00, 32'h8000, 32'hFF00});
		add_row(FMT_RGBA16, FMT_RGBA8, {32'hFFFF_FFFF, 32'h0, 32'h1_00FF, 32'h0_ABCD},
			1, {32'hFF, 32'h0, 32'h0, 32'hAB});
		add_row(5'd17, FMT_RGBA8, {4{32'hFFFF_FFFF}}, 1, '0);
		add_row(FMT_RGBA8, FMT_BAD_MAX, {4{32'hFFFF_FFFF}}, 1, '0);
		add_row(FMT_R32F, FMT_R8, {32'h5, 32'h5, 32'h5, 32'h7FC0_0000}, 1, '0);
		add_row(FMT_R32F, FMT_R8, {32'h0, 32'h0, 32'h0, 32'h7F80_0000}, 1, {96'h0, 32'hFF});
		add_row(FMT_R32F, FMT_R8, {32'h0, 32'h0, 32'h0, 32'hBF80_0000}, 1, '0);
		add_row(FMT_RGBA32F, FMT_RGBA16F, {32'hFFC0_1234, 32'h4780_0000, 32'h3380_0000,
			32'h3F80_0001}, 0, '0);
		add_row(FMT_RGBA32F, FMT_RG11B10F, {32'h0, 32'h7FFF_FFFF, 32'h4780_0000, 32'hFF80_0000},
			0, '0);
		add_row(FMT_RG11B10F, FMT_RGBA32F, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 0, '0);
		add_row(FMT_RG11B10F, FMT_RGBA32F, {32'h0, 32'h0, 32'h0, 32'h7C1F_03FF}, 0, '0);
		add_row(FMT_RG11B10F, FMT_RG11B10F, {32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF},
			1, {96'h0, 32'hFFFF_FFFF});
		add_row(FMT_RGBA4, FMT_RGB565, {32'h0, 32'h0, 32'h0, 32'hFFFF_9A5F}, 0, '0);
		add_row(FMT_RGB5A1, FMT_RGB10A2, {32'h0, 32'h0, 32'h0, 32'h0001_FFFE}, 0, '0);
		add_row(FMT_RGB10A2, FMT_RGBA16F, {32'h0, 32'h0, 32'h0, 32'hC00F_FC01}, 0, '0);
		add_row(FMT_R16, FMT_RG8, {32'h1, 32'h1, 32'h1, 32'hFFFF_8080}, 0, '0);
		add_row(FMT_RG16F, FMT_RGBA4, {32'h7, 32'h7, 32'hFFFF_8001, 32'h0000_3C00}, 0, '0);
		add_row(FMT_RG8, FMT_R16, {32'h0, 32'h0, 32'hFF, 32'h80}, 0, '0);
		add_row(FMT_RGBA16F, FMT_RG32F, {32'h7E01, 32'hFC00, 32'h0001, 32'h83FF}, 0, '0);
		add_row(FMT_RGB565, FMT_RG11B10F, {32'h0, 32'h0, 32'h0, 32'hFFFF}, 0, '0);
		add_row(FMT_RG32F, FMT_RG16, {32'h1, 32'h1, 32'h3F00_0000, 32'h3F7F_FFFF}, 0, '0);
		add_row(FMT_R16F, FMT_RGBA8, {32'h1, 32'h1, 32'h1, 32'hFFFF_3800}, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			set_formats(dir_tab[i].src, dir_tab[i].dst);
			send_pixel(dir_tab[i].pix, dir_tab[i].fixed, dir_tab[i].want);
		end

		sent = 0;
		for (int ph = 0; sent < RAND_ITEMS; ph++) begin
			case (ph)
				0: begin s = FMT_R8; t = FMT_RG11B10F; end
				1: begin s = FMT_RG11B10F; t = FMT_R8; end
				2: begin s = FMT_RGBA8; t = FMT_RGBA16; end
				3: begin s = FMT_RGBA16; t = FMT_RGBA8; end
				default: begin
					s = rand_fmt();
					t = ($urandom_range(0, 9) == 0) ? s : rand_fmt();
				end
			endcase
			set_formats(s, t);
			quiet = (ph % 5 == 4);
			if (ph == 6)
				hold_req = 1'b1;
			plen = $urandom_range(10, 50);
			for (int k = 0; k < plen; k++) begin
				for (int i = 0; i < 4; i++)
					v[i] = rand_word();
				send_pixel(v, 0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b1;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS pixel_format_converter");
		else
			$display("FAIL pixel_format_converter");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_decode.sv
hw/rtl/pfc_float_enc.sv
hw/rtl/pfc_quant.sv
hw/rtl/pixel_format_converter.sv
dv/tb_pixel_format_converter.sv
